// ===== src/tli_pkg.sv =====
// Shared constants, codes and widths for the table linear interpolator.
package tli_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 128;

   localparam int INDEX_W  = 7;
   localparam int DATA_W   = 32;
   localparam int CFG_W    = 8;
   localparam int STATUS_W = 2;

   // The divider starts with the high dividend word as its remainder, so one
   // quotient bit per data bit is enough.
   localparam int DIV_STEPS = DATA_W;

   localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd2;

endpackage

// ===== src/tli_req_if.sv =====
// Request channel interface: table writes and interpolation queries.
interface tli_req_if import tli_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [INDEX_W-1:0]       entry_index;
   logic [DATA_W-1:0]        entry_abscissa;
   logic signed [DATA_W-1:0] entry_value;
   logic [DATA_W-1:0]        query_point;

   modport source (
      output valid, func, entry_index, entry_abscissa, entry_value, query_point,
      input  ready
   );

   modport sink (
      input  valid, func, entry_index, entry_abscissa, entry_value, query_point,
      output ready
   );
endinterface

// ===== src/tli_rsp_if.sv =====
// Response channel interface: interpolated value and status.
interface tli_rsp_if import tli_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] interpolated_value;
   logic [STATUS_W-1:0]      status;

   modport source (
      output valid, interpolated_value, status,
      input  ready
   );

   modport sink (
      input  valid, interpolated_value, status,
      output ready
   );
endinterface

// ===== src/tli_divider.sv =====
// Restoring divider, one quotient bit per cycle, for quotients that fit one word.
module tli_divider import tli_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [2*DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0]   divisor,
   output logic                done,
   output logic [DATA_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;

   logic [DATA_W:0] shifted;
   logic [DATA_W:0] trial;

   // The caller guarantees that the high dividend word is below the divisor.
   assign shifted = {rem_ff, low_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[2*DATA_W-1:DATA_W];
         low_in  = dividend[DATA_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            low_in = {low_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

// ===== src/table_linear_interpolator_top.sv =====
// Top level of the table linear interpolator: table memory, scan sequencer, output register.
// A table write leaves the sequencer idle, so the block is ready again in the next cycle.
// A query above the last abscissa is resolved in ST_LAST, one below the first abscissa in ST_FIRST.
// A query that stops at entry i reads one entry per cycle from the single memory read port,
// then runs one multiply and the bit-serial divider before its result reaches ST_OUT.
// Reset (synchronous, active high) clears the sequencer and the output valid flag and sets
// the entry count to 128; the table contents are kept and hold no meaning until written.
module table_linear_interpolator_top import tli_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   tli_req_if.sink          req_bus,
   tli_rsp_if.source        rsp_bus
);

   localparam int AW = $clog2(TABLE_DEPTH);

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LAST  = 8'b0000_0010,
      ST_FIRST = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIVS  = 8'b0010_0000,
      ST_DIVW  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration register: number of entries that a query searches.
   logic [CFG_W-1:0] csr_count_ff, csr_count_in;

   // Query context.
   logic [DATA_W-1:0]   q_ff, q_in;
   logic [AW-1:0]       last_ff, last_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [2*DATA_W-1:0] prev_ff, prev_in;

   // Operands of the interpolation arithmetic.
   logic [DATA_W-1:0]   mag_ff, mag_in;
   logic [DATA_W-1:0]   off_ff, off_in;
   logic [DATA_W-1:0]   span_ff, span_in;
   logic [DATA_W-1:0]   base_ff, base_in;
   logic                neg_ff, neg_in;
   logic [2*DATA_W-1:0] prod_ff, prod_in;

   // Finished result waiting for the output register.
   logic [DATA_W-1:0]   res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Table memory: abscissa in the upper word, value in the lower word.
   logic [2*DATA_W-1:0] mem [TABLE_DEPTH];
   logic [2*DATA_W-1:0] rd_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;

   logic                req_xfer;
   logic [DATA_W-1:0]   rd_a, rd_v, prev_a, prev_v;
   logic [31:0]         cfg_wide;
   logic [31:0]         last_wide;
   logic [AW-1:0]       last_calc;

   logic                div_start;
   logic                div_done;
   logic [DATA_W-1:0]   div_quot;

   logic [DATA_W+1:0]   sum;
   logic                sum_ovf;
   logic [DATA_W-1:0]   sat_value;

   logic                out_free;
   logic                rsp_load;

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // The entry count is clamped to at least two and at most the table depth, and
   // the index of the last searched entry is kept.
   assign cfg_wide = 32'(csr_count_ff);
   always_comb begin
      if (cfg_wide < 32'd2) begin
         last_wide = 32'd1;
      end else if (cfg_wide > 32'(TABLE_DEPTH)) begin
         last_wide = 32'(TABLE_DEPTH - 1);
      end else begin
         last_wide = cfg_wide - 32'd1;
      end
   end
   assign last_calc = AW'(last_wide);

   // A write to a position outside the table is dropped.
   assign mem_we = req_xfer && (req_bus.func == FUNC_WRITE) &&
                   (32'(req_bus.entry_index) < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(req_bus.entry_index)] <= {req_bus.entry_abscissa, req_bus.entry_value};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_a   = rd_ff[2*DATA_W-1:DATA_W];
   assign rd_v   = rd_ff[DATA_W-1:0];
   assign prev_a = prev_ff[2*DATA_W-1:DATA_W];
   assign prev_v = prev_ff[DATA_W-1:0];

   // The quotient never exceeds the value difference, so the high product word is
   // always below the span and the divider needs only one word of quotient bits.
   tli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Add or subtract the scaled step from the lower value and saturate to one word.
   always_comb begin
      if (neg_ff) begin
         sum = {{2{base_ff[DATA_W-1]}}, base_ff} - {2'b00, div_quot};
      end else begin
         sum = {{2{base_ff[DATA_W-1]}}, base_ff} + {2'b00, div_quot};
      end
      sum_ovf = (sum[DATA_W+1] != sum[DATA_W]) || (sum[DATA_W] != sum[DATA_W-1]);
      if (!sum_ovf) begin
         sat_value = sum[DATA_W-1:0];
      end else if (sum[DATA_W+1]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   // Sequencer. The last searched entry is read first for the upper bound, then
   // entry zero for the lower bound, then the scan streams one entry per cycle:
   // while entry idx is checked, entry idx + 1 is already being read.
   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      mag_in        = mag_ff;
      off_in        = off_ff;
      span_in       = span_ff;
      base_in       = base_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = last_calc;
            if (req_xfer && (req_bus.func == FUNC_QUERY)) begin
               q_in     = req_bus.query_point;
               last_in  = last_calc;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            rd_addr = '0;
            if (q_ff > rd_a) begin
               res_value_in  = '0;
               res_status_in = STATUS_ABOVE;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            rd_addr = AW'(1);
            if (q_ff < rd_a) begin
               res_value_in  = '0;
               res_status_in = STATUS_BELOW;
               state_in      = ST_OUT;
            end else begin
               prev_in  = rd_ff;
               idx_in   = AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + AW'(1);
            if (rd_a > q_ff) begin
               span_in  = rd_a - prev_a;
               off_in   = q_ff - prev_a;
               base_in  = prev_v;
               neg_in   = $signed(rd_v) < $signed(prev_v);
               mag_in   = ($signed(rd_v) < $signed(prev_v)) ? (prev_v - rd_v)
                                                            : (rd_v - prev_v);
               state_in = ST_MUL;
            end else if (idx_ff == last_ff) begin
               // The point sits on the last abscissa.
               res_value_in  = rd_v;
               res_status_in = STATUS_OK;
               state_in      = ST_OUT;
            end else begin
               prev_in = rd_ff;
               idx_in  = idx_ff + AW'(1);
            end
         end
         ST_MUL: begin
            prod_in  = {{DATA_W{1'b0}}, mag_ff} * {{DATA_W{1'b0}}, off_ff};
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               res_value_in  = sat_value;
               res_status_in = STATUS_OK;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: it takes a new result once the previous transfer is done
   // or completes in the same cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load = (state_ff == ST_OUT) && out_free;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end else begin
         rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
         rsp_value_in  = rsp_value_ff;
         rsp_status_in = rsp_status_ff;
      end
   end

   assign csr_count_in = csr_wr_en ? csr_wr_data : csr_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_count_ff <= CFG_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_count_ff <= csr_count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      prev_ff       <= prev_in;
      mag_ff        <= mag_in;
      off_ff        <= off_in;
      span_ff       <= span_in;
      base_ff       <= base_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.interpolated_value = rsp_value_ff;
   assign rsp_bus.status             = rsp_status_ff;

`ifndef ASSERT_OFF
   // The divider finishes only while the sequencer waits for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVW))
      else $error("divider finished outside the wait state");

   // The scan never runs past the last searched entry.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= last_ff))
      else $error("scan index beyond the last searched entry");

   // The lower entry of the segment never lies above the point, so the span is positive.
   a_prev_not_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (prev_ff[2*DATA_W-1:DATA_W] <= q_ff))
      else $error("lower segment abscissa above the query point");

   // An accepted query starts with the upper bound check.
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_bus.func == FUNC_QUERY)) |=> (state_ff == ST_LAST))
      else $error("accepted query did not start the bound check");
`endif

endmodule

// ===== dv/tb_table_linear_interpolator_top.sv =====
// Self-checking testbench for the table linear interpolator top level.
module tb_table_linear_interpolator_top;
   import tli_pkg::*;

   localparam int DEPTH      = TABLE_DEPTH_DEFAULT;
   // The slowest query scans the whole table and then runs the serial divider;
   // SETTLE is sized to cover any work still inside the block.
   localparam int SETTLE     = 300;
   localparam int ITEM_GOAL  = 1780;
   localparam int QUIET_MARK = 1450;
   localparam int LIMIT_TIME = 20_000_000;

   // One request transfer as the generator plans it.
   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  abscissa;
      logic [DATA_W-1:0]  value;
      logic [DATA_W-1:0]  point;
   } table_req_type;

   // One interpolation answer as the block should return it.
   typedef struct packed {
      logic [DATA_W-1:0]   value;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   tli_req_if req_bus ();
   tli_rsp_if rsp_bus ();

   table_linear_interpolator_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // Mirror of the block's table and entry count, updated in transfer order.
   logic [DATA_W-1:0]        mirror_x [DEPTH];
   logic signed [DATA_W-1:0] mirror_y [DEPTH];
   int unsigned              mirror_count = int'(CFG_RESET);

   // The generator's own view of the table abscissas, updated as items are
   // queued, so that it can aim query points at the table that will be in place.
   logic [DATA_W-1:0] plan_x [DEPTH];

   table_req_type req_backlog [$];
   outcome_type   awaited_answers [$];
   table_req_type in_flight;
   outcome_type   oldest_answer;

   int sent_count     = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int hold_gap       = 0;
   bit quiet          = 1'b0;

   always #5 clock = ~clock;

   // The generous limit: a hung handshake or a lost answer ends here.
   initial begin
      #(LIMIT_TIME);
      $display("tb_table_linear_interpolator_top: FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Counts below two search two entries, counts above the depth search all.
   function automatic int clamp_count(input int unsigned cfg);
      if (cfg < 2) return 2;
      if (cfg > DEPTH) return DEPTH;
      return int'(cfg);
   endfunction

   // Expected answer for a query point against the mirrored table. The scan
   // stops at the first entry above the point, and the entry before it is
   // never above the point, so the span is always positive.
   function automatic outcome_type interpolate_at(input logic [DATA_W-1:0] q);
      outcome_type       o;
      int                n;
      int                i;
      int                hit;
      longint            s0;
      longint            s1;
      longint            diff;
      longint            r;
      longint unsigned   span;
      longint unsigned   off;
      longint unsigned   mag;
      longint unsigned   quo;
      n = clamp_count(mirror_count);
      o.value = '0;
      o.status = STATUS_OK;
      if (q > mirror_x[n-1]) begin
         o.status = STATUS_ABOVE;
         return o;
      end
      if (q < mirror_x[0]) begin
         o.status = STATUS_BELOW;
         return o;
      end
      hit = 0;
      for (i = 1; i < n && hit == 0; i++) begin
         if (mirror_x[i] > q) hit = i;
      end
      if (hit == 0) begin
         o.value = mirror_y[n-1];
         return o;
      end
      s0   = longint'(mirror_y[hit-1]);
      s1   = longint'(mirror_y[hit]);
      diff = s1 - s0;
      span = longint'(mirror_x[hit]) - longint'(mirror_x[hit-1]);
      off  = longint'(q) - longint'(mirror_x[hit-1]);
      mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
      quo  = (mag * off) / span;
      r    = (diff < 0) ? s0 - longint'(quo) : s0 + longint'(quo);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      o.value = r[DATA_W-1:0];
      return o;
   endfunction

   task automatic queue_write(input int idx, input logic [DATA_W-1:0] x,
                              input logic [DATA_W-1:0] y);
      table_req_type t;
      t.func     = FUNC_WRITE;
      t.index    = idx[INDEX_W-1:0];
      t.abscissa = x;
      t.value    = y;
      t.point    = $urandom;
      req_backlog.push_back(t);
      plan_x[idx] = x;
      sent_count++;
   endtask

   task automatic queue_query(input logic [DATA_W-1:0] q);
      table_req_type t;
      t.func     = FUNC_QUERY;
      t.index    = INDEX_W'($urandom);
      t.abscissa = $urandom;
      t.value    = $urandom;
      t.point    = q;
      req_backlog.push_back(t);
      sent_count++;
   endtask

   // Values lean toward the extremes now and then so that the difference
   // between neighbors reaches its full 32-bit magnitude.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Query points: mostly inside the table, with exact hits on abscissas,
   // the two ends and their outer neighbors, and some points anywhere.
   function automatic logic [DATA_W-1:0] pick_point(input int n);
      longint unsigned lo;
      longint unsigned hi;
      int              r;
      lo = 64'(plan_x[0]);
      hi = 64'(plan_x[n-1]);
      r  = $urandom_range(0, 99);
      if (r < 55) begin
         if (hi >= lo) return DATA_W'(lo + ({32'd0, $urandom} % (hi - lo + 1)));
         return $urandom;
      end
      if (r < 70) return plan_x[$urandom_range(0, n - 1)];
      if (r < 75) return DATA_W'(hi);
      if (r < 80) return DATA_W'(hi + 1);
      if (r < 85) return DATA_W'(lo - 1);
      if (r < 90) return DATA_W'(lo);
      return $urandom;
   endfunction

   // Writes entries 0 to n-1 with strictly increasing abscissas. The gap size
   // varies from tiny to one that spreads the table over the whole range.
   task automatic load_table(input int n);
      longint unsigned   gap_max;
      longint unsigned   total;
      longint unsigned   base;
      longint unsigned   gap [DEPTH];
      logic [DATA_W-1:0] x;
      int                k;
      case ($urandom_range(0, 3))
         0: gap_max = 16;
         1: gap_max = 4096;
         2: gap_max = 64'd1 << 20;
         default: gap_max = 64'hFFFF_FFFF / longint'(n);
      endcase
      total = 0;
      for (k = 1; k < n; k++) begin
         gap[k] = 1 + ({32'd0, $urandom} % gap_max);
         total += gap[k];
      end
      base = {32'd0, $urandom} % (64'h1_0000_0000 - total);
      x = base[DATA_W-1:0];
      for (k = 0; k < n; k++) begin
         if (k > 0) x = x + gap[k][DATA_W-1:0];
         queue_write(k, x, pick_value());
      end
   endtask

   // Waits until every queued item has been transferred and every answer has
   // come back, then lets the block settle.
   task automatic wait_idle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_bus.valid || awaited_answers.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // The count register is written only while the block has nothing to do.
   task automatic set_entry_count(input int cfg);
      wait_idle();
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= CFG_W'(cfg);
      mirror_count = cfg;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   // A random phase loads a fresh sorted table and then mixes queries with
   // value rewrites, order-breaking writes and writes elsewhere in the table.
   task automatic random_phase(input int cfg, input bit set_cfg);
      int n;
      int k;
      int r;
      int idx;
      int nq;
      if (set_cfg) set_entry_count(cfg);
      n = clamp_count(cfg);
      load_table(n);
      nq = $urandom_range(15, 60);
      for (k = 0; k < nq; k++) begin
         r = $urandom_range(0, 99);
         if (r < 82) begin
            queue_query(pick_point(n));
         end else if (r < 91) begin
            idx = $urandom_range(0, n - 1);
            queue_write(idx, plan_x[idx], pick_value());
         end else if (r < 96) begin
            queue_write($urandom_range(0, n - 1), $urandom, pick_value());
         end else begin
            queue_write($urandom_range(0, DEPTH - 1), $urandom, $urandom);
         end
      end
   endtask

   // Request driver. The current item is held until the block takes it; the
   // expected answer is worked out at the edge of the transfer, so table
   // writes and queries reach the mirror in the block's own order.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (in_flight.func == FUNC_WRITE) begin
               mirror_x[in_flight.index] = in_flight.abscissa;
               mirror_y[in_flight.index] = in_flight.value;
            end else begin
               awaited_answers.push_back(interpolate_at(in_flight.point));
            end
         end
         if (req_bus.valid && !req_bus.ready) begin
            // The offered item stays on the bus until its transfer.
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            // Idle burst that begins with this cycle; send_gap holds the rest of it.
            send_gap = $urandom_range(0, 10);
            req_bus.valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            in_flight = req_backlog.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.func           <= in_flight.func;
            req_bus.entry_index    <= in_flight.index;
            req_bus.entry_abscissa <= in_flight.abscissa;
            req_bus.entry_value    <= in_flight.value;
            req_bus.query_point    <= in_flight.point;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result monitor. Every answer transfer is matched against the oldest
   // expected answer; ready drops in bursts like the sender's gaps.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_answers.size() == 0) begin
               flag_mismatch($sformatf("answer with no query waiting: value %0d status %0d",
                                       $signed(rsp_bus.interpolated_value), rsp_bus.status));
            end else begin
               oldest_answer = awaited_answers.pop_front();
               if (rsp_bus.interpolated_value !== oldest_answer.value)
                  flag_mismatch($sformatf("interpolated_value %0d, expected %0d",
                                          $signed(rsp_bus.interpolated_value),
                                          $signed(oldest_answer.value)));
               if (rsp_bus.status !== oldest_answer.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_bus.status, oldest_answer.status));
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_gap = $urandom_range(0, 10);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int cfg;
      int r;
      // Every block input starts at a known value.
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_bus.valid          = 1'b0;
      req_bus.func           = FUNC_WRITE;
      req_bus.entry_index    = '0;
      req_bus.entry_abscissa = '0;
      req_bus.entry_value    = '0;
      req_bus.query_point    = '0;
      rsp_bus.ready          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The reset count searches the full table, so the whole table is
      // loaded before the first query ever reads it.
      random_phase(int'(CFG_RESET), 1'b0);

      // Directed part on a four-entry table: minimum and maximum abscissas
      // and values, exact hits, the point at the last abscissa, points below
      // and above the range, and a table that is no longer sorted.
      set_entry_count(4);
      queue_write(0, 32'h0000_0000, 32'h8000_0000);
      queue_write(1, 32'h0000_0010, 32'h7FFF_FFFF);
      queue_write(2, 32'h8000_0000, 32'h0000_0000);
      queue_write(3, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_query(32'h0000_0000);
      queue_query(32'h0000_0008);
      queue_query(32'h0000_0010);
      queue_query(32'h4000_0000);
      queue_query(32'hFFFF_FFFE);
      queue_query(32'hFFFF_FFFF);
      queue_write(0, 32'h0000_0005, 32'h0001_0000);
      queue_query(32'h0000_0000);
      queue_query(32'h0000_0004);
      queue_query(32'h0000_0005);
      queue_write(3, 32'hFFFF_0000, 32'h7FFF_FFFF);
      queue_query(32'hFFFF_FFFF);
      queue_query(32'hFFFF_0000);
      // Entry 2 now lies below entry 1: the scan must still pick the right pair.
      queue_write(2, 32'h0000_0001, 32'hFFFF_0000);
      queue_query(32'h0000_0020);
      queue_query(32'h0000_0010);

      // Counts of zero and one both search the first two entries.
      set_entry_count(0);
      queue_query(32'h0000_0005);
      queue_query(32'h0000_000A);
      queue_query(32'h0000_0011);
      set_entry_count(1);
      queue_query(32'h0000_0004);
      queue_query(32'h0000_0010);

      // Random part: the largest register value first, then the smallest
      // meaningful count, then mostly small tables with a few large ones.
      random_phase(255, 1'b1);
      random_phase(2, 1'b1);
      while (sent_count < ITEM_GOAL) begin
         // The tail of the run goes without any idling on either side.
         if (sent_count > QUIET_MARK) quiet = 1'b1;
         r = $urandom_range(0, 9);
         if (r < 6) cfg = $urandom_range(2, 12);
         else if (r < 8) cfg = $urandom_range(13, 40);
         else if (r == 8) cfg = $urandom_range(0, 1);
         else cfg = $urandom_range(128, 255);
         random_phase(cfg, 1'b1);
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("tb_table_linear_interpolator_top: PASS");
      else
         $display("tb_table_linear_interpolator_top: FAIL");
      $finish;
   end

endmodule

// ===== table_linear_interpolator_top.f =====
src/tli_pkg.sv
src/tli_req_if.sv
src/tli_rsp_if.sv
src/tli_divider.sv
src/table_linear_interpolator_top.sv
dv/tb_table_linear_interpolator_top.sv
